// ===== rtl/cidpw_pkg.sv =====
package cidpw_pkg;

    localparam int NUM_BUSES_DEF = 2;
    localparam int NUM_IDS_DEF   = 11;
    localparam int KNOWN_IDS     = 11;

    localparam int OP_W    = 2;
    localparam int BUS_W   = 2;
    localparam int ID_W    = 29;
    localparam int TIME_W  = 32;
    localparam int MINF_W  = 16;
    localparam int CNT_W   = 16;
    localparam int TOTAL_W = 20;
    localparam int MASK_W  = 11;
    localparam int STATE_W = 2;
    localparam int SLOT_W  = 4;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 32;
    localparam int S_DATA_W = 72;
    localparam int M_DATA_W = 72;

    localparam logic [CNT_W-1:0]  CNT_MAX          = 16'hFFFF;
    localparam logic [TIME_W-1:0] LISTEN_LEN_RESET = 32'd3000;
    localparam logic [MINF_W-1:0] MIN_FRAMES_RESET = 16'd3;

    localparam logic [CFG_IDX_W-1:0] REG_LISTEN_LEN = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_FRAMES = 1'd1;

    localparam logic [STATE_W-1:0] RS_IDLE    = 2'd0;
    localparam logic [STATE_W-1:0] RS_RUNNING = 2'd1;
    localparam logic [STATE_W-1:0] RS_DONE    = 2'd2;

    localparam logic [ID_W-1:0] SLOT_IDS [KNOWN_IDS] = '{
        29'h370, 29'h39B, 29'h399, 29'h3FD, 29'h3EE, 29'h129,
        29'h273, 29'h102, 29'h119, 29'h3E9, 29'h3C2
    };

    typedef enum logic [OP_W-1:0] {
        OP_START = 2'd0,
        OP_FRAME = 2'd1,
        OP_TICK  = 2'd2,
        OP_QUERY = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_RUN  = 3'b010,
        PH_DONE = 3'b100
    } phase_t;

    // per-item control handed from the front end to the counter stage
    typedef struct packed {
        logic              clear;
        logic              inc_en;
        logic [SLOT_W-1:0] slot;
        logic [BUS_W-1:0]  bus;
        logic              bus_ok;
        phase_t            phase;
        logic [TIME_W-1:0] deadline;
        logic [TIME_W-1:0] now;
    } item_ctrl_t;

    typedef struct packed {
        logic [STATE_W-1:0] run_state;
        logic [MASK_W-1:0]  seen_mask;
        logic [TOTAL_W-1:0] frame_total;
        logic               bus_active;
        logic [TIME_W-1:0]  ms_left;
    } result_t;

    // returns {hit, slot}
    function automatic logic [SLOT_W:0] slot_lookup(input logic [ID_W-1:0] id);
        logic              hit;
        logic [SLOT_W-1:0] slot;
        hit  = 1'b0;
        slot = '0;
        for (int i = KNOWN_IDS - 1; i >= 0; i--) begin
            if (id == SLOT_IDS[i]) begin
                hit  = 1'b1;
                slot = SLOT_W'(i);
            end
        end
        return {hit, slot};
    endfunction

endpackage

// ===== rtl/cidpw_ctrl.sv =====
module cidpw_ctrl
    import cidpw_pkg::*;
#(
    parameter int NUM_BUSES = NUM_BUSES_DEF,
    parameter int NUM_IDS   = NUM_IDS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              accept,
    input  op_t               op,
    input  logic [BUS_W-1:0]  bus,
    input  logic [ID_W-1:0]   can_id,
    input  logic [TIME_W-1:0] now_ms,
    input  logic [TIME_W-1:0] listen_len,
    output item_ctrl_t        ctrl
);

    phase_t            phase_reg, phase_next;
    logic [TIME_W-1:0] deadline_reg, deadline_next;
    logic [SLOT_W:0]   lookup;
    logic              bus_ok;
    logic              running;
    logic              before_deadline;
    logic              slot_ok;
    logic              clear;
    logic              inc_en;

    assign lookup          = slot_lookup(can_id);
    assign bus_ok          = {1'b0, bus} < (BUS_W + 1)'(NUM_BUSES);
    assign running         = (phase_reg == PH_RUN);
    assign before_deadline = now_ms < deadline_reg;
    assign slot_ok         = lookup[SLOT_W] &&
                             ({1'b0, lookup[SLOT_W-1:0]} < (SLOT_W + 1)'(NUM_IDS));

    always_comb begin
        phase_next    = phase_reg;
        deadline_next = deadline_reg;
        clear         = 1'b0;
        inc_en        = 1'b0;
        case (op)
            OP_START: begin
                clear         = 1'b1;
                phase_next    = PH_RUN;
                deadline_next = now_ms + listen_len;
            end
            OP_FRAME: begin
                inc_en = running && before_deadline && bus_ok && slot_ok;
            end
            OP_TICK: begin
                if (running && !before_deadline) begin
                    phase_next = PH_DONE;
                end
            end
            OP_QUERY: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            deadline_reg <= '0;
        end else if (accept) begin
            phase_reg    <= phase_next;
            deadline_reg <= deadline_next;
        end
    end

    always_comb begin
        ctrl.clear    = clear;
        ctrl.inc_en   = inc_en;
        ctrl.slot     = lookup[SLOT_W-1:0];
        ctrl.bus      = bus;
        ctrl.bus_ok   = bus_ok;
        ctrl.phase    = phase_next;
        ctrl.deadline = deadline_next;
        ctrl.now      = now_ms;
    end

endmodule

// ===== rtl/cidpw_cnt_mem.sv =====
module cidpw_cnt_mem
    import cidpw_pkg::*;
#(
    parameter int NUM_BUSES = NUM_BUSES_DEF,
    parameter int NUM_IDS   = NUM_IDS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              accept,
    input  item_ctrl_t        ctrl,
    input  logic [MINF_W-1:0] min_frames,
    input  logic              advance,
    output logic              busy,
    output result_t           res
);

    localparam int AW    = (NUM_BUSES > 1) ? $clog2(NUM_BUSES) : 1;
    localparam int CNT_SPAN = NUM_IDS * CNT_W;
    localparam int ROW_W = CNT_SPAN + TOTAL_W;

    // one row per bus: all slot counters plus their running total
    logic [ROW_W-1:0]     row_mem [NUM_BUSES];
    logic [NUM_BUSES-1:0] row_valid_reg, row_valid_next;

    logic [ROW_W-1:0] rd_row_reg;
    logic [ROW_W-1:0] fwd_row_reg;
    logic             fwd_hit_reg;
    logic             rd_valid_reg;
    logic             s1_valid_reg;
    item_ctrl_t       s1_reg;

    logic [AW-1:0]      rd_addr;
    logic [AW-1:0]      wr_addr;
    logic               wr_en;
    logic [ROW_W-1:0]   old_row;
    logic [ROW_W-1:0]   new_row;
    logic [NUM_IDS-1:0] seen;
    logic               any_bump;
    logic [TOTAL_W-1:0] total_new;
    logic [STATE_W-1:0] run_state;

    assign rd_addr = ctrl.bus_ok ? ctrl.bus[AW-1:0] : '0;
    assign wr_addr = s1_reg.bus_ok ? s1_reg.bus[AW-1:0] : '0;
    assign wr_en   = advance && s1_valid_reg && s1_reg.bus_ok;
    assign busy    = s1_valid_reg;

    always_ff @(posedge aclk) begin
        if (accept) begin
            rd_row_reg <= row_mem[rd_addr];
        end
        if (wr_en) begin
            row_mem[wr_addr] <= new_row;
        end
    end

    // a start wipes every row at once, later than any write-back at the same edge
    always_comb begin
        row_valid_next = row_valid_reg;
        if (wr_en) begin
            row_valid_next[wr_addr] = 1'b1;
        end
        if (accept && ctrl.clear) begin
            row_valid_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_valid_reg <= '0;
            s1_valid_reg  <= 1'b0;
        end else begin
            row_valid_reg <= row_valid_next;
            if (accept) begin
                s1_valid_reg <= 1'b1;
            end else if (advance) begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_reg       <= ctrl;
            rd_valid_reg <= ctrl.bus_ok && row_valid_reg[rd_addr];
            fwd_hit_reg  <= wr_en && (s1_reg.bus == ctrl.bus);
            fwd_row_reg  <= new_row;
        end
    end

    always_comb begin
        if (s1_reg.clear) begin
            old_row = '0;
        end else if (fwd_hit_reg) begin
            old_row = fwd_row_reg;
        end else if (rd_valid_reg) begin
            old_row = rd_row_reg;
        end else begin
            old_row = '0;
        end
    end

    always_comb begin
        logic [CNT_W-1:0] cnt;
        logic             bump;
        any_bump = 1'b0;
        new_row  = old_row;
        seen     = '0;
        for (int i = 0; i < NUM_IDS; i++) begin
            cnt  = old_row[i*CNT_W +: CNT_W];
            bump = s1_reg.inc_en && (s1_reg.slot == SLOT_W'(i)) && (cnt != CNT_MAX);
            cnt  = cnt + CNT_W'(bump);
            any_bump = any_bump | bump;
            new_row[i*CNT_W +: CNT_W] = cnt;
            seen[i] = cnt >= min_frames;
        end
        total_new = old_row[CNT_SPAN +: TOTAL_W] + TOTAL_W'(any_bump);
        new_row[CNT_SPAN +: TOTAL_W] = total_new;
    end

    always_comb begin
        case (s1_reg.phase)
            PH_IDLE: run_state = RS_IDLE;
            PH_RUN:  run_state = RS_RUNNING;
            PH_DONE: run_state = RS_DONE;
            default: run_state = RS_IDLE;
        endcase
    end

    always_comb begin
        res.run_state   = run_state;
        res.seen_mask   = '0;
        res.frame_total = '0;
        if (s1_reg.bus_ok) begin
            for (int i = 0; i < NUM_IDS && i < MASK_W; i++) begin
                res.seen_mask[i] = seen[i];
            end
            res.frame_total = total_new;
        end
        res.bus_active = (s1_reg.bus == '0) || (res.frame_total != '0);
        if ((s1_reg.phase == PH_RUN) && (s1_reg.deadline > s1_reg.now)) begin
            res.ms_left = s1_reg.deadline - s1_reg.now;
        end else begin
            res.ms_left = '0;
        end
    end

endmodule

// ===== rtl/can_id_presence_window_counter_top.sv =====
// CAN id presence counter over a listen window. Each item carries an operation
// (start, received frame, time tick, bus query) and returns exactly one result:
// run state plus the per-slot seen mask, frame total, bus activity and ms left
// for the addressed bus, all taken after the item's own update. One item can be
// accepted every clock unless the output is held; its result passes through the
// counter stage register and then the output register. While a result waits
// for m_tready the counter stage holds one more item, then the input stalls.
// The counters sit in a row memory with one row per bus that is read when an
// item is accepted and written back when it leaves the counter stage; a row
// written back at the same edge is forwarded to the next item on that bus. A
// start clears all rows at once through per-row valid bits, so there is no
// clearing pass after reset. The user must write the window length and
// min_frames on the cfg port only while the block is idle; it is not enforced.
module can_id_presence_window_counter_top
    import cidpw_pkg::*;
#(
    parameter int NUM_BUSES = NUM_BUSES_DEF,
    parameter int NUM_IDS   = NUM_IDS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    // op[1:0], bus[3:2], can_id[32:4], now_ms[64:33], zero fill
    input  logic [S_DATA_W-1:0]   s_tdata,

    output logic                  m_tvalid,
    input  logic                  m_tready,
    // run_state[1:0], seen_mask[12:2], frame_total[32:13], bus_active[33],
    // ms_left[65:34], zero fill
    output logic [M_DATA_W-1:0]   m_tdata
);

    logic [TIME_W-1:0] listen_len_reg;
    logic [MINF_W-1:0] min_frames_reg;

    logic       accept;
    logic       advance;
    logic       busy;
    item_ctrl_t ctrl;
    result_t    res;
    result_t    out_reg;
    logic       m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            listen_len_reg <= LISTEN_LEN_RESET;
            min_frames_reg <= MIN_FRAMES_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_LISTEN_LEN: listen_len_reg <= cfg_wdata[TIME_W-1:0];
                REG_MIN_FRAMES: min_frames_reg <= cfg_wdata[MINF_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // the counter stage moves on whenever the output register is free or draining
    assign advance  = busy && (!m_valid_reg || m_tready);
    assign s_tready = !busy || advance;
    assign accept   = s_tvalid && s_tready;

    cidpw_ctrl #(
        .NUM_BUSES (NUM_BUSES),
        .NUM_IDS   (NUM_IDS)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .op         (op_t'(s_tdata[1:0])),
        .bus        (s_tdata[3:2]),
        .can_id     (s_tdata[32:4]),
        .now_ms     (s_tdata[64:33]),
        .listen_len (listen_len_reg),
        .ctrl       (ctrl)
    );

    cidpw_cnt_mem #(
        .NUM_BUSES (NUM_BUSES),
        .NUM_IDS   (NUM_IDS)
    ) u_cnt_mem (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .ctrl       (ctrl),
        .min_frames (min_frames_reg),
        .advance    (advance),
        .busy       (busy),
        .res        (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'b0, out_reg.ms_left, out_reg.bus_active, out_reg.frame_total,
                       out_reg.seen_mask, out_reg.run_state};

endmodule
